// File: rtl/tec_pkg.sv
`default_nettype none
package tec_pkg;

  localparam logic [2:0] ENC_ANSI        = 3'd0;
  localparam logic [2:0] ENC_UTF8        = 3'd1;
  localparam logic [2:0] ENC_UTF8_BOM    = 3'd2;
  localparam logic [2:0] ENC_UTF16LE     = 3'd3;
  localparam logic [2:0] ENC_UTF16LE_BOM = 3'd4;
  localparam logic [2:0] ENC_BINARY      = 3'd5;

  localparam logic [2:0] LIM_ANY   = 3'd0;
  localparam logic [2:0] LIM_A0_BF = 3'd1;
  localparam logic [2:0] LIM_80_9F = 3'd2;
  localparam logic [2:0] LIM_90_BF = 3'd3;
  localparam logic [2:0] LIM_80_8F = 3'd4;

  localparam logic [7:0] BOM16_B0 = 8'hFF;
  localparam logic [7:0] BOM16_B1 = 8'hFE;
  localparam logic [7:0] BOM8_B0  = 8'hEF;
  localparam logic [7:0] BOM8_B1  = 8'hBB;
  localparam logic [7:0] BOM8_B2  = 8'hBF;

  localparam logic [1:0] PAIR_ZERO_MAX = 2'd3;
  localparam logic [2:0] BYTE_ZERO_MAX = 3'd7;
  localparam logic [2:0] BYTE_ZERO_MIN_UTF16 = 3'd3;
  localparam logic UTF8_PREF_RESET = 1'b1;

  typedef struct packed {
    logic [1:0]  byte_count;
    logic        odd_position;
    logic [23:0] head;
    logic [1:0]  pair_zero;
    logic [2:0]  byte_zero;
  } stats_t;

  function automatic logic [2:0] classify(input stats_t st, input logic utf8_pref,
                                          input logic utf8_ok);
    logic [2:0] enc;
    enc = ENC_UTF8;
    priority if (st.byte_count < 2'd2) begin
      enc = ENC_ANSI;
    end else if (st.pair_zero == PAIR_ZERO_MAX) begin
      enc = ENC_BINARY;
    end else if (st.head[7:0] == BOM16_B0 && st.head[15:8] == BOM16_B1) begin
      enc = ENC_UTF16LE_BOM;
    end else if (st.byte_zero > BYTE_ZERO_MIN_UTF16 && !st.odd_position) begin
      enc = ENC_UTF16LE;
    end else if (st.byte_count < 2'd3) begin
      enc = ENC_ANSI;
    end else if (st.head[7:0] == BOM8_B0 && st.head[15:8] == BOM8_B1 &&
                 st.head[23:16] == BOM8_B2) begin
      enc = ENC_UTF8_BOM;
    end else if (!utf8_pref || !utf8_ok) begin
      enc = ENC_ANSI;
    end else begin
      enc = ENC_UTF8;
    end
    return enc;
  endfunction

endpackage
`default_nettype wire

// File: rtl/text_encoding_classifier_unit.sv
`default_nettype none
// The input register holds a byte; a last byte's encoding goes to the result register.
// Throughput: one byte per cycle when not stalled; non-last bytes produce no result.
// The input register accepts a new byte while a finished result waits to be taken,
// unless the byte it holds is itself a last byte, which waits for the result register.
// Reset (rst_n low, synchronous) clears all counters, the UTF-8 state and the valids,
// and sets the UTF-8 preference to 1.
module text_encoding_classifier_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_encoding,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data
);
  import tec_pkg::*;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       step;
  logic       prefer_r;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [2:0] out_enc_r;
  stats_t     stats_nxt;
  logic       utf8_ok_nxt;

  assign step     = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !step;

  tec_stats u_stats (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .clear     (s1_last_r),
    .data_byte (s1_byte_r),
    .stats_nxt (stats_nxt)
  );

  tec_utf8 u_utf8 (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .clear       (s1_last_r),
    .data_byte   (s1_byte_r),
    .utf8_ok_nxt (utf8_ok_nxt)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prefer_r    <= UTF8_PREF_RESET;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        prefer_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
    if (step && s1_last_r) begin
      out_enc_r <= classify(stats_nxt, prefer_r, utf8_ok_nxt);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_encoding = out_enc_r;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_last_r && out_valid_r))
    else $error("Input stalled without a blocked last byte.");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (step && s1_last_r) |=> out_valid_r)
    else $error("Last byte did not produce a result.");

  a_code_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_enc_r <= ENC_BINARY))
    else $error("Encoding code out of range.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_enc_r)))
    else $error("Pending result was lost or overwritten.");

endmodule
`default_nettype wire

// File: rtl/tec_stats.sv
`default_nettype none
module tec_stats (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step,
  input  wire logic           clear,
  input  wire logic [7:0]     data_byte,
  output tec_pkg::stats_t     stats_nxt
);
  import tec_pkg::*;

  stats_t     stats_r;
  stats_t     upd;
  logic [7:0] pending_r;
  logic [7:0] pending_nxt;
  logic       b_zero;
  logic       p_zero;
  logic [3:0] zero_sum;

  always_comb begin
    upd         = stats_r;
    pending_nxt = pending_r;
    b_zero      = (data_byte == 8'd0);
    p_zero      = (pending_r == 8'd0);
    zero_sum    = {1'b0, stats_r.byte_zero} + {3'd0, p_zero} + {3'd0, b_zero};
    if (stats_r.byte_count != 2'd3) begin
      unique case (stats_r.byte_count)
        2'd0:    upd.head[7:0]   = data_byte;
        2'd1:    upd.head[15:8]  = data_byte;
        default: upd.head[23:16] = data_byte;
      endcase
      upd.byte_count = stats_r.byte_count + 2'd1;
    end
    if (stats_r.odd_position) begin
      if (p_zero && b_zero && stats_r.pair_zero != PAIR_ZERO_MAX) begin
        upd.pair_zero = stats_r.pair_zero + 2'd1;
      end
      upd.byte_zero = (zero_sum > {1'b0, BYTE_ZERO_MAX}) ? BYTE_ZERO_MAX : zero_sum[2:0];
      upd.odd_position = 1'b0;
    end else begin
      pending_nxt      = data_byte;
      upd.odd_position = 1'b1;
    end
    stats_nxt = upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stats_r   <= '0;
      pending_r <= '0;
    end else if (step) begin
      if (clear) begin
        stats_r   <= '0;
        pending_r <= '0;
      end else begin
        stats_r   <= upd;
        pending_r <= pending_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/tec_utf8.sv
`default_nettype none
module tec_utf8 (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic       clear,
  input  wire logic [7:0] data_byte,
  output logic            utf8_ok_nxt
);
  import tec_pkg::*;

  logic [1:0] remaining_r;
  logic [1:0] remaining_nxt;
  logic [2:0] limit_r;
  logic [2:0] limit_nxt;
  logic       invalid_r;
  logic       invalid_nxt;
  logic [7:0] lo;
  logic [7:0] hi;

  always_comb begin
    remaining_nxt = remaining_r;
    limit_nxt     = limit_r;
    invalid_nxt   = invalid_r;
    lo            = 8'h80;
    hi            = 8'hBF;
    unique case (limit_r)
      LIM_A0_BF: lo = 8'hA0;
      LIM_80_9F: hi = 8'h9F;
      LIM_90_BF: lo = 8'h90;
      LIM_80_8F: hi = 8'h8F;
      default: ;
    endcase
    if (!invalid_r) begin
      if (remaining_r != 2'd0) begin
        if (data_byte < lo || data_byte > hi) begin
          invalid_nxt = 1'b1;
        end else begin
          limit_nxt     = LIM_ANY;
          remaining_nxt = remaining_r - 2'd1;
        end
      end else begin
        limit_nxt = LIM_ANY;
        priority if (data_byte <= 8'h7F) begin
          remaining_nxt = 2'd0;
        end else if (data_byte >= 8'hC2 && data_byte <= 8'hDF) begin
          remaining_nxt = 2'd1;
        end else if (data_byte == 8'hE0) begin
          remaining_nxt = 2'd2;
          limit_nxt     = LIM_A0_BF;
        end else if (data_byte == 8'hED) begin
          remaining_nxt = 2'd2;
          limit_nxt     = LIM_80_9F;
        end else if (data_byte >= 8'hE1 && data_byte <= 8'hEF) begin
          remaining_nxt = 2'd2;
        end else if (data_byte == 8'hF0) begin
          remaining_nxt = 2'd3;
          limit_nxt     = LIM_90_BF;
        end else if (data_byte >= 8'hF1 && data_byte <= 8'hF3) begin
          remaining_nxt = 2'd3;
        end else if (data_byte == 8'hF4) begin
          remaining_nxt = 2'd3;
          limit_nxt     = LIM_80_8F;
        end else begin
          invalid_nxt = 1'b1;
        end
      end
    end
    utf8_ok_nxt = !invalid_nxt && (remaining_nxt == 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remaining_r <= '0;
      limit_r     <= LIM_ANY;
      invalid_r   <= 1'b0;
    end else if (step) begin
      if (clear) begin
        remaining_r <= '0;
        limit_r     <= LIM_ANY;
        invalid_r   <= 1'b0;
      end else begin
        remaining_r <= remaining_nxt;
        limit_r     <= limit_nxt;
        invalid_r   <= invalid_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// File: test/text_encoding_classifier_unit_check.sv
`default_nettype none
module text_encoding_classifier_unit_check (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic [2:0] out_encoding,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,
  output int              mismatches,
  output int              encodings_owed
);
  import tec_pkg::*;

  logic        utf8_pref;
  logic [1:0]  seen;
  logic        odd_pos;
  logic [7:0]  even_byte;
  logic [23:0] head;
  logic [1:0]  zero_pairs;
  logic [2:0]  zero_bytes;
  logic [1:0]  cont_left;
  logic [2:0]  cont_range;
  logic        utf8_bad;
  logic [2:0]  pending_encodings[$];
  int          errors = 0;

  assign mismatches = errors;

  function automatic void clear_scan();
    seen       = 2'd0;
    odd_pos    = 1'b0;
    even_byte  = 8'h00;
    head       = 24'h000000;
    zero_pairs = 2'd0;
    zero_bytes = 3'd0;
    cont_left  = 2'd0;
    cont_range = LIM_ANY;
    utf8_bad   = 1'b0;
  endfunction

  function automatic void scan_byte(input logic [7:0] b, input logic last);
    logic [7:0] lo;
    logic [7:0] hi;
    logic [2:0] enc;
    lo = 8'h80;
    hi = 8'hBF;
    if (seen < 2'd3) begin
      head[8*seen +: 8] = b;
      seen = seen + 2'd1;
    end
    if (odd_pos) begin
      if (even_byte == 8'h00 && b == 8'h00 && zero_pairs < 2'd3) zero_pairs = zero_pairs + 2'd1;
      if (even_byte == 8'h00 && zero_bytes < 3'd7) zero_bytes = zero_bytes + 3'd1;
      if (b == 8'h00 && zero_bytes < 3'd7) zero_bytes = zero_bytes + 3'd1;
      odd_pos = 1'b0;
    end else begin
      even_byte = b;
      odd_pos = 1'b1;
    end
    if (!utf8_bad) begin
      if (cont_left != 2'd0) begin
        case (cont_range)
          LIM_A0_BF: lo = 8'hA0;
          LIM_80_9F: hi = 8'h9F;
          LIM_90_BF: lo = 8'h90;
          LIM_80_8F: hi = 8'h8F;
          default: ;
        endcase
        if (b < lo || b > hi) begin
          utf8_bad = 1'b1;
        end else begin
          cont_range = LIM_ANY;
          cont_left = cont_left - 2'd1;
        end
      end else begin
        cont_range = LIM_ANY;
        if (b >= 8'h80) begin
          if (b >= 8'hC2 && b <= 8'hDF) begin
            cont_left = 2'd1;
          end else if (b == 8'hE0) begin
            cont_left = 2'd2;
            cont_range = LIM_A0_BF;
          end else if (b == 8'hED) begin
            cont_left = 2'd2;
            cont_range = LIM_80_9F;
          end else if (b >= 8'hE1 && b <= 8'hEF) begin
            cont_left = 2'd2;
          end else if (b == 8'hF0) begin
            cont_left = 2'd3;
            cont_range = LIM_90_BF;
          end else if (b >= 8'hF1 && b <= 8'hF3) begin
            cont_left = 2'd3;
          end else if (b == 8'hF4) begin
            cont_left = 2'd3;
            cont_range = LIM_80_8F;
          end else begin
            utf8_bad = 1'b1;
          end
        end
      end
    end
    if (last) begin
      if (seen < 2'd2) begin
        enc = ENC_ANSI;
      end else if (zero_pairs == 2'd3) begin
        enc = ENC_BINARY;
      end else if (head[7:0] == BOM16_B0 && head[15:8] == BOM16_B1) begin
        enc = ENC_UTF16LE_BOM;
      end else if (zero_bytes > 3'd3 && !odd_pos) begin
        enc = ENC_UTF16LE;
      end else if (seen < 2'd3) begin
        enc = ENC_ANSI;
      end else if (head[7:0] == BOM8_B0 && head[15:8] == BOM8_B1 && head[23:16] == BOM8_B2) begin
        enc = ENC_UTF8_BOM;
      end else if (!utf8_pref || utf8_bad || cont_left != 2'd0) begin
        enc = ENC_ANSI;
      end else begin
        enc = ENC_UTF8;
      end
      pending_encodings.push_back(enc);
      clear_scan();
    end
  endfunction

  always @(posedge clk) begin
    logic [2:0] want;
    if (!rst_n) begin
      clear_scan();
      utf8_pref = UTF8_PREF_RESET;
      pending_encodings.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_encodings.size() == 0) begin
          $error("encoding: no transaction expected, actual %0d", out_encoding);
          errors <= errors + 1;
        end else begin
          want = pending_encodings.pop_front();
          if (out_encoding !== want) begin
            $error("encoding: expected %0d, actual %0d", want, out_encoding);
            errors <= errors + 1;
          end
        end
      end
      if (cfg_wr_en) utf8_pref = cfg_wr_data;
      if (in_valid && !in_stall) scan_byte(in_data_byte, in_last_byte);
    end
    encodings_owed <= pending_encodings.size();
  end

endmodule
`default_nettype wire

// File: test/text_encoding_classifier_unit_tb.sv
`default_nettype none
module text_encoding_classifier_unit_tb;
  import tec_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_encoding;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  bit         calm = 1'b0;
  int         mismatches;
  int         encodings_owed;
  logic [7:0] file_bytes[$];

  always #6 clk = ~clk;

  text_encoding_classifier_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_encoding (out_encoding),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  text_encoding_classifier_unit_check i_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_encoding   (out_encoding),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .mismatches     (mismatches),
    .encodings_owed (encodings_owed)
  );

  function automatic logic [7:0] byte_between(input int unsigned lo, input int unsigned hi);
    logic [31:0] r;
    r = $urandom_range(hi, lo);
    return r[7:0];
  endfunction

  function automatic logic [20:0] pick_char();
    logic [20:0] corner_points [16] = '{21'h0, 21'h7F, 21'h80, 21'h7FF, 21'h800, 21'hFFF,
                                        21'h1000, 21'hD7FF, 21'hE000, 21'hFFFD, 21'hFFFF,
                                        21'h10000, 21'h3FFFF, 21'h40000, 21'h100000,
                                        21'h10FFFF};
    logic [31:0] r;
    case ($urandom_range(0, 4))
      0: r = $urandom_range(0, 'h7F);
      1: r = $urandom_range('h80, 'h7FF);
      2: begin
        r = $urandom_range('h800, 'hF7FF);
        if (r >= 'hD800) r = r + 'h800;
      end
      3: r = $urandom_range('h10000, 'h10FFFF);
      default: r = {11'd0, corner_points[$urandom_range(0, 15)]};
    endcase
    return r[20:0];
  endfunction

  function automatic void put_char(input logic [20:0] cp);
    if (cp < 21'h80) begin
      file_bytes.push_back({1'b0, cp[6:0]});
    end else if (cp < 21'h800) begin
      file_bytes.push_back({3'b110, cp[10:6]});
      file_bytes.push_back({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      file_bytes.push_back({4'b1110, cp[15:12]});
      file_bytes.push_back({2'b10, cp[11:6]});
      file_bytes.push_back({2'b10, cp[5:0]});
    end else begin
      file_bytes.push_back({5'b11110, cp[20:18]});
      file_bytes.push_back({2'b10, cp[17:12]});
      file_bytes.push_back({2'b10, cp[11:6]});
      file_bytes.push_back({2'b10, cp[5:0]});
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_file();
    if ($urandom_range(0, 5) == 0) calm <= !calm;
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (encodings_owed != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_prefer(input logic v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : result_pacing
    int hold;
    forever begin
      hold = calm ? 0 : $urandom_range(0, 17);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    int phase;
    int budget;
    int variant;
    int mark;
    logic [20:0] cp;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    file_bytes = {8'h00};
    send_file();
    file_bytes = {8'h41, 8'hFF};
    send_file();
    file_bytes = {BOM16_B0, BOM16_B1};
    send_file();
    file_bytes = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_file();
    file_bytes = {BOM8_B0, BOM8_B1, BOM8_B2};
    send_file();
    file_bytes = {8'h00, 8'h00, 8'h41, 8'h00, 8'h42, 8'h00};
    send_file();
    file_bytes = {8'hE2, 8'h82, 8'hAC};
    send_file();
    file_bytes = {8'hC0, 8'h80, 8'h7F};
    send_file();

    for (phase = 0; phase < 5; phase++) begin
      if (phase > 0) begin
        settle();
        set_prefer(phase % 2 == 0);
      end
      budget = 0;
      while (budget < 160) begin
        file_bytes.delete();
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            if ($urandom_range(0, 3) == 0) file_bytes = {BOM8_B0, BOM8_B1, BOM8_B2};
            repeat ($urandom_range(1, 8)) put_char(pick_char());
          end
          4: begin
            repeat ($urandom_range(0, 3)) put_char(pick_char());
            variant = $urandom_range(0, 8);
            case (variant)
              0: begin
                file_bytes.push_back(byte_between('hC0, 'hC1));
                file_bytes.push_back(byte_between('h80, 'hBF));
              end
              1: begin
                file_bytes.push_back(8'hE0);
                file_bytes.push_back(byte_between('h80, 'h9F));
                file_bytes.push_back(byte_between('h80, 'hBF));
              end
              2: begin
                file_bytes.push_back(8'hF0);
                file_bytes.push_back(byte_between('h80, 'h8F));
                file_bytes.push_back(byte_between('h80, 'hBF));
                file_bytes.push_back(byte_between('h80, 'hBF));
              end
              3: begin
                file_bytes.push_back(8'hED);
                file_bytes.push_back(byte_between('hA0, 'hBF));
                file_bytes.push_back(byte_between('h80, 'hBF));
              end
              4: begin
                file_bytes.push_back(8'hF4);
                file_bytes.push_back(byte_between('h90, 'hBF));
                file_bytes.push_back(byte_between('h80, 'hBF));
                file_bytes.push_back(byte_between('h80, 'hBF));
              end
              5: file_bytes.push_back(byte_between('hF5, 'hFF));
              6: file_bytes.push_back(byte_between('h80, 'hBF));
              7: begin
                file_bytes.push_back(byte_between('hC2, 'hF4));
                if ($urandom_range(0, 1) == 0) file_bytes.push_back(byte_between('h00, 'h7F));
                else file_bytes.push_back(byte_between('hC0, 'hFF));
              end
              default: begin
                do cp = pick_char(); while (cp < 21'h80);
                mark = file_bytes.size();
                put_char(cp);
                repeat ($urandom_range(1, file_bytes.size() - mark - 1))
                  void'(file_bytes.pop_back());
              end
            endcase
            if (variant != 8) repeat ($urandom_range(0, 3)) put_char(pick_char());
          end
          5: begin
            if ($urandom_range(0, 2) == 0) file_bytes = {BOM16_B0, BOM16_B1};
            repeat ($urandom_range(1, 6)) begin
              if ($urandom_range(0, 3) == 0) file_bytes.push_back(byte_between('h00, 'hFF));
              else file_bytes.push_back(byte_between('h20, 'h7E));
              file_bytes.push_back(8'h00);
            end
            case ($urandom_range(0, 3))
              0: file_bytes.push_back(byte_between('h00, 'hFF));
              1: if (file_bytes.size() > 1) void'(file_bytes.pop_back());
              default: ;
            endcase
          end
          6: begin
            repeat ($urandom_range(2, 12)) begin
              if ($urandom_range(0, 1) == 0) file_bytes.push_back(8'h00);
              else file_bytes.push_back(byte_between('h00, 'hFF));
            end
          end
          7: begin
            case ($urandom_range(0, 3))
              0: file_bytes = {BOM16_B0, BOM16_B1};
              1: file_bytes = {BOM8_B0, BOM8_B1};
              default: repeat ($urandom_range(1, 2)) file_bytes.push_back(byte_between('h00, 'hFF));
            endcase
          end
          8: begin
            repeat ($urandom_range(1, 10)) file_bytes.push_back(byte_between('h00, 'hFF));
          end
          default: begin
            case ($urandom_range(0, 4))
              0: file_bytes = {BOM8_B0, BOM8_B1, byte_between('h00, 'hFF)};
              1: file_bytes = {BOM8_B0, byte_between('h00, 'hFF), BOM8_B2};
              2: file_bytes = {BOM16_B0, byte_between('h00, 'hFF)};
              3: file_bytes = {byte_between('h00, 'hFF), BOM16_B1};
              default: begin
                file_bytes = {BOM16_B0, BOM16_B1};
                repeat ($urandom_range(0, 8)) begin
                  if ($urandom_range(0, 1) == 0) file_bytes.push_back(8'h00);
                  else file_bytes.push_back(byte_between('h00, 'hFF));
                end
              end
            endcase
            repeat ($urandom_range(0, 4)) put_char(pick_char());
          end
        endcase
        if (file_bytes.size() == 0) file_bytes.push_back(byte_between('h00, 'hFF));
        budget += file_bytes.size();
        send_file();
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("text_encoding_classifier_unit_tb OK");
    end else begin
      $display("text_encoding_classifier_unit_tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("text_encoding_classifier_unit_tb NOT OK");
    $finish;
  end

endmodule
`default_nettype wire
